// ----- sv/sfla_pkg.sv -----
`timescale 1ns / 1ps

package sfla_pkg;

	localparam int SLOT_W        = 12;
	localparam int CNT_W         = 13;
	localparam int BYTES_W       = 48;
	localparam int DEF_MAX_SLOTS = 4096;

	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 13'd4096;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_ADJUST  = 2'd2;

	// request to the byte tracker, issued on the accept cycle
	typedef struct packed {
		logic        load;
		logic [32:0] addend;    // two's complement, sign in bit 32
	} byte_cmd_t;

endpackage

// ----- sv/sfla_link_ram.sv -----
`timescale 1ns / 1ps

module sfla_link_ram #(
	parameter int DEPTH  = sfla_pkg::DEF_MAX_SLOTS,
	parameter int DATA_W = sfla_pkg::SLOT_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/sfla_byte_tracker.sv -----
`timescale 1ns / 1ps

module sfla_byte_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sfla_pkg::byte_cmd_t            cmd,
	input  logic                           commit,
	output logic [sfla_pkg::BYTES_W-1:0]   total_next,
	output logic [sfla_pkg::BYTES_W-1:0]   peak_next
);
	import sfla_pkg::*;

	localparam logic [BYTES_W-1:0] TOTAL_MAX = '1;

	logic [BYTES_W-1:0] total_q;
	logic [BYTES_W-1:0] peak_q;
	logic [BYTES_W-1:0] sum_s1;
	logic [BYTES_W+1:0] sum_wide;
	logic [BYTES_W-1:0] sum_sat;

	// two guard bits: top one flags below zero, next flags above max
	always_comb begin
		sum_wide = {2'b00, total_q} + {{(BYTES_W - 31){cmd.addend[32]}}, cmd.addend};
		priority if (sum_wide[BYTES_W+1]) begin
			sum_sat = '0;
		end else if (sum_wide[BYTES_W]) begin
			sum_sat = TOTAL_MAX;
		end else begin
			sum_sat = sum_wide[BYTES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_s1 <= sum_sat;
		end
	end

	assign total_next = sum_s1;
	assign peak_next  = (sum_s1 > peak_q) ? sum_s1 : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			peak_q  <= '0;
		end else if (commit) begin
			total_q <= total_next;
			peak_q  <= peak_next;
		end
	end

endmodule

// ----- sv/slot_free_list_allocator.sv -----
`timescale 1ns / 1ps

// Slot free-list allocator.
// Input channel (in_valid/in_ready) carries kind, slot, block_size and
// size_delta: kind 0 allocates a slot, 1 releases one, 2 adjusts the byte
// total. Every input beat yields exactly one output beat (out_valid/out_ready)
// with status, granted_slot, used_slots, total_bytes and peak_bytes.
// Released slots are reused last-in first-out; with none waiting, slots are
// granted fresh in ascending order.
// The input beat is registered into the execute stage (ST_EXEC), which loads
// the result register once out_valid is low or out_ready is high. in_ready is
// low in ST_EXEC, so a new item waits for the last to leave it; the link read
// that yields the new head after a pop is issued on accept. A finished result
// waits in the output register while the next item is accepted; the second
// result holds in the execute stage until out_ready takes the first.
// Reset clears the free list, counts, byte total and peak, and sets
// slot_count to 4096. The link memory is not cleared: it is only read
// at entries written by a prior release. cfg_wr_en/cfg_wr_data write
// slot_count; the user must write only while the block is idle (unchecked).

module slot_free_list_allocator #(
	parameter int MAX_SLOTS = sfla_pkg::DEF_MAX_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [sfla_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [sfla_pkg::SLOT_W-1:0]   slot,
	input  logic [31:0]                   block_size,
	input  logic signed [31:0]            size_delta,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [sfla_pkg::SLOT_W-1:0]   granted_slot,
	output logic [sfla_pkg::CNT_W-1:0]    used_slots,
	output logic [sfla_pkg::BYTES_W-1:0]  total_bytes,
	output logic [sfla_pkg::BYTES_W-1:0]  peak_bytes
);
	import sfla_pkg::*;

	localparam int AW       = $clog2(MAX_SLOTS);
	localparam int POOL_CAP = (MAX_SLOTS > 8191) ? 8191 : MAX_SLOTS;
	localparam int WIDE_W   = 17;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  head_q;
	logic               list_valid_q;
	logic [CNT_W-1:0]   fresh_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   slot_count_q;

	logic               alloc_s1;
	logic               ok_s1;
	logic               pop_s1;
	logic [SLOT_W-1:0]  granted_s1;

	logic [CNT_W-1:0]   pool_n;
	logic [CNT_W-1:0]   used_inc;
	logic               accept;
	logic               exec_fire;
	logic               is_alloc;
	logic               full;
	logic               do_pop;
	logic               do_fresh;
	logic               alloc_ok;
	logic               rel_ok;
	logic [WIDE_W-1:0]  head_wide;
	logic [WIDE_W-1:0]  slot_wide;
	logic [SLOT_W-1:0]  link_rdata;
	byte_cmd_t          byte_cmd;
	logic [BYTES_W-1:0] total_next;
	logic [BYTES_W-1:0] peak_next;

	assign pool_n    = (slot_count_q > CNT_W'(POOL_CAP)) ? CNT_W'(POOL_CAP) : slot_count_q;
	assign used_inc  = used_q + 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_ready && in_valid;
	assign exec_fire = (state_q == ST_EXEC) && (!out_valid || out_ready);

	assign is_alloc  = (kind == KIND_ALLOC);
	assign full      = (used_q >= pool_n);
	assign do_pop    = is_alloc && !full && list_valid_q;
	assign do_fresh  = is_alloc && !full && !list_valid_q && (fresh_q < pool_n);
	assign alloc_ok  = do_pop || do_fresh;

	assign head_wide = {{(WIDE_W - SLOT_W){1'b0}}, head_q};
	assign slot_wide = {{(WIDE_W - SLOT_W){1'b0}}, slot};
	assign rel_ok    = (kind == KIND_RELEASE) && (slot_wide < WIDE_W'(MAX_SLOTS));

	always_comb begin
		byte_cmd.load = accept;
		priority if (alloc_ok) begin
			byte_cmd.addend = {1'b0, block_size};
		end else if (kind == KIND_ADJUST) begin
			byte_cmd.addend = {size_delta[31], size_delta};
		end else begin
			byte_cmd.addend = '0;
		end
	end

	sfla_link_ram #(
		.DEPTH  (MAX_SLOTS),
		.DATA_W (SLOT_W)
	) u_link_ram (
		.clk   (clk),
		.we    (accept && rel_ok),
		.waddr (slot_wide[AW-1:0]),
		.wdata (head_q),
		.re    (accept && do_pop),
		.raddr (head_wide[AW-1:0]),
		.rdata (link_rdata)
	);

	sfla_byte_tracker u_byte_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (byte_cmd),
		.commit     (exec_fire),
		.total_next (total_next),
		.peak_next  (peak_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid    <= 1'b0;
			head_q       <= '0;
			list_valid_q <= 1'b0;
			fresh_q      <= '0;
			used_q       <= '0;
			slot_count_q <= SLOT_COUNT_RST;
			alloc_s1     <= 1'b0;
			ok_s1        <= 1'b0;
			pop_s1       <= 1'b0;
			granted_s1   <= '0;
			status       <= 1'b0;
			granted_slot <= '0;
			used_slots   <= '0;
			total_bytes  <= '0;
			peak_bytes   <= '0;
		end else begin
			if (cfg_wr_en) begin
				slot_count_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (out_ready) begin
						out_valid <= 1'b0;
					end
					if (in_valid) begin
						state_q    <= ST_EXEC;
						alloc_s1   <= is_alloc;
						ok_s1      <= alloc_ok;
						pop_s1     <= do_pop;
						granted_s1 <= do_pop ? head_q : fresh_q[SLOT_W-1:0];
						if (do_pop) begin
							used_q       <= used_inc;
							list_valid_q <= (used_inc < fresh_q);
						end
						if (do_fresh) begin
							fresh_q <= fresh_q + 1'b1;
							used_q  <= used_inc;
						end
						if (rel_ok) begin
							head_q       <= slot;
							list_valid_q <= 1'b1;
							if (used_q != '0) begin
								used_q <= used_q - 1'b1;
							end
						end
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q      <= ST_IDLE;
						out_valid    <= 1'b1;
						// new head arrives from the link read issued on accept
						if (pop_s1) begin
							head_q <= link_rdata;
						end
						status       <= alloc_s1 && !ok_s1;
						granted_slot <= ok_s1 ? granted_s1 : '0;
						used_slots   <= used_q;
						total_bytes  <= total_next;
						peak_bytes   <= peak_next;
					end
				end
			endcase
		end
	end

endmodule
